/* rtl/assert_macros.svh */
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define MFQS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define MFQS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mfqs_pkg.sv */
package mfqs_pkg;

   // Default sizes of the process table.
   localparam int DEF_MAX_PROCS  = 16;
   localparam int DEF_BURST_BITS = 12;

   // Fixed field widths of the request and response channels.
   localparam int NUM_LEVELS = 3;
   localparam int LEVEL_W    = 2;
   localparam int IN_BURST_W = 12;
   localparam int ID_W       = 5;
   localparam int TIME_W     = 16;
   localparam int PERIOD_W   = 4;
   localparam int CSR_IDX_W  = 1;

   // Queue levels.
   localparam logic [LEVEL_W-1:0] LVL0 = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL1 = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL2 = 2'd2;

   // Request actions.
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL0_PERIOD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL1_PERIOD = 1'd1;
   localparam logic [PERIOD_W-1:0]  RST_LEVEL0_PERIOD = 4'd2;
   localparam logic [PERIOD_W-1:0]  RST_LEVEL1_PERIOD = 4'd3;

endpackage

/* rtl/mfqs_ram.sv */
module mfqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/multilevel_feedback_queue_scheduler.sv */
// Channel   Direction  Handshake             Contents
// req_      in         req_valid/req_ready   action, burst_length
// rsp_      out        rsp_valid/rsp_ready   one result per request
// csr_      in         csr_we                level period registers
//
// A load, a rejected request and a tick with every level empty show their response
// from the accepting edge on, so such requests can follow back to back while each
// response is taken. A tick that serves a process holds req_ready low while the
// sequencer reads the queue memory and then the process table; its response is
// registered in the execute state, after which the next request can be taken.
// Reset clears the queue pointers, counters, clock and rsp_valid, and presets periods.
// A new request is taken only when the sequencer is idle and the response
// register is empty or being emptied in the same cycle.
module multilevel_feedback_queue_scheduler
   import mfqs_pkg::*;
#(
   parameter int MAX_PROCS  = DEF_MAX_PROCS,
   parameter int BURST_BITS = DEF_BURST_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [IN_BURST_W-1:0] req_burst_length,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_accepted,
   output logic [ID_W-1:0]       rsp_served_id,
   output logic [LEVEL_W-1:0]    rsp_served_level,
   output logic                  rsp_completed,
   output logic [TIME_W-1:0]     rsp_finish_time,
   output logic [TIME_W-1:0]     rsp_delay_time,
   output logic                  rsp_all_done,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [PERIOD_W-1:0]   csr_wdata
);

   localparam int SLOT_W     = $clog2(MAX_PROCS);
   localparam int CNT_W      = $clog2(MAX_PROCS + 1);
   localparam int SUM_W      = SLOT_W + 1;
   localparam int FIFO_DEPTH = 3 << SLOT_W;
   localparam int FIFO_AW    = SLOT_W + LEVEL_W;
   localparam int TBL_W      = 2 * BURST_BITS;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FIFO = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [SLOT_W-1:0]     head_ff  [NUM_LEVELS];
   logic [SLOT_W-1:0]     head_in  [NUM_LEVELS];
   logic [CNT_W-1:0]      count_ff [NUM_LEVELS];
   logic [CNT_W-1:0]      count_in [NUM_LEVELS];
   logic [TIME_W-1:0]     clock_ff, clock_in;
   logic [CNT_W-1:0]      loaded_ff, loaded_in;
   logic                  running_ff, running_in;
   logic [PERIOD_W-1:0]   period0_ff, period0_in;
   logic [PERIOD_W-1:0]   period1_ff, period1_in;
   logic [LEVEL_W-1:0]    lvl_ff, lvl_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_accepted_ff, rsp_accepted_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [LEVEL_W-1:0]    rsp_level_ff, rsp_level_in;
   logic                  rsp_completed_ff, rsp_completed_in;
   logic [TIME_W-1:0]     rsp_finish_ff, rsp_finish_in;
   logic [TIME_W-1:0]     rsp_wait_ff, rsp_wait_in;
   logic                  rsp_all_done_ff, rsp_all_done_in;

   // Memory ports.
   logic                  fifo_we, fifo_re;
   logic [FIFO_AW-1:0]    fifo_waddr, fifo_raddr;
   logic [SLOT_W-1:0]     fifo_wdata, fifo_rdata;
   logic                  tbl_we, tbl_re;
   logic [SLOT_W-1:0]     tbl_waddr, tbl_raddr;
   logic [TBL_W-1:0]      tbl_wdata, tbl_rdata;

   // Per-level tail positions and the level a tick would serve.
   logic [SLOT_W-1:0]     tail_pos [NUM_LEVELS];
   logic [SUM_W-1:0]      tail_sum [NUM_LEVELS];
   logic [LEVEL_W-1:0]    pick_lvl;
   logic [SLOT_W-1:0]     pick_head;
   logic                  any_queued;

   // Working values of the update step.
   logic [BURST_BITS-1:0] new_burst;
   logic [BURST_BITS-1:0] cur_burst, cur_rem, new_rem;
   logic [TIME_W-1:0]     new_clock, period_mask;
   logic [PERIOD_W-1:0]   period_sel;
   logic                  demote;
   logic [LEVEL_W-1:0]    tgt_lvl;
   logic                  load_ok;
   logic                  req_fire, rsp_free;

   assign req_fire = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;

   // Tail of each level is head plus count, wrapped once.
   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         tail_sum[l] = SUM_W'(head_ff[l]) + SUM_W'(count_ff[l]);
         if (tail_sum[l] >= SUM_W'(MAX_PROCS)) begin
            tail_pos[l] = SLOT_W'(tail_sum[l] - SUM_W'(MAX_PROCS));
         end else begin
            tail_pos[l] = SLOT_W'(tail_sum[l]);
         end
      end
   end

   // Highest non-empty level and its head position.
   always_comb begin
      any_queued = 1'b1;
      if (count_ff[0] != '0) begin
         pick_lvl  = LVL0;
         pick_head = head_ff[0];
      end else if (count_ff[1] != '0) begin
         pick_lvl  = LVL1;
         pick_head = head_ff[1];
      end else begin
         pick_lvl   = LVL2;
         pick_head  = head_ff[2];
         any_queued = (count_ff[2] != '0);
      end
   end

   // Arithmetic of the served process.
   assign cur_burst  = tbl_rdata[TBL_W-1:BURST_BITS];
   assign cur_rem    = tbl_rdata[BURST_BITS-1:0];
   assign new_rem    = cur_rem - BURST_BITS'(1);
   assign new_clock  = clock_ff + TIME_W'(1);
   assign period_sel = (lvl_ff == LVL0) ? period0_ff : period1_ff;
   assign period_mask = (TIME_W'(1) << period_sel) - TIME_W'(1);
   assign demote     = (lvl_ff != LVL2) && ((new_clock & period_mask) == '0);
   assign tgt_lvl    = demote ? (lvl_ff + LEVEL_W'(1)) : lvl_ff;

   // Load checks.
   assign new_burst = BURST_BITS'(req_burst_length);
   assign load_ok   = !running_ff && (loaded_ff < CNT_W'(MAX_PROCS)) && (new_burst != '0);

   // Sequencer and next-state logic.
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      clock_in   = clock_ff;
      loaded_in  = loaded_ff;
      running_in = running_ff;
      lvl_in     = lvl_ff;
      slot_in    = slot_ff;

      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_accepted_in  = rsp_accepted_ff;
      rsp_id_in        = rsp_id_ff;
      rsp_level_in     = rsp_level_ff;
      rsp_completed_in = rsp_completed_ff;
      rsp_finish_in    = rsp_finish_ff;
      rsp_wait_in      = rsp_wait_ff;
      rsp_all_done_in  = rsp_all_done_ff;

      fifo_we    = 1'b0;
      fifo_waddr = {LVL0, tail_pos[0]};
      fifo_wdata = loaded_ff[SLOT_W-1:0];
      fifo_re    = 1'b0;
      fifo_raddr = {pick_lvl, pick_head};
      tbl_we     = 1'b0;
      tbl_waddr  = loaded_ff[SLOT_W-1:0];
      tbl_wdata  = {new_burst, new_burst};
      tbl_re     = 1'b0;
      tbl_raddr  = fifo_rdata;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_action == ACT_LOAD) begin
                  // Load answers at once; a rejected load leaves state alone.
                  rsp_valid_in     = 1'b1;
                  rsp_level_in     = LVL0;
                  rsp_completed_in = 1'b0;
                  rsp_finish_in    = clock_ff;
                  rsp_wait_in      = '0;
                  if (load_ok) begin
                     fifo_we         = 1'b1;
                     tbl_we          = 1'b1;
                     count_in[0]     = count_ff[0] + CNT_W'(1);
                     loaded_in       = loaded_ff + CNT_W'(1);
                     rsp_accepted_in = 1'b1;
                     rsp_id_in       = ID_W'(SUM_W'(loaded_ff[SLOT_W-1:0]) + SUM_W'(1));
                     rsp_all_done_in = 1'b0;
                  end else begin
                     rsp_accepted_in = 1'b0;
                     rsp_id_in       = '0;
                     rsp_all_done_in = !any_queued;
                  end
               end else begin
                  running_in = 1'b1;
                  if (any_queued) begin
                     // Fetch the head slot of the chosen level.
                     fifo_re  = 1'b1;
                     lvl_in   = pick_lvl;
                     state_in = ST_FIFO;
                  end else begin
                     rsp_valid_in     = 1'b1;
                     rsp_accepted_in  = 1'b0;
                     rsp_id_in        = '0;
                     rsp_level_in     = LVL0;
                     rsp_completed_in = 1'b0;
                     rsp_finish_in    = clock_ff;
                     rsp_wait_in      = '0;
                     rsp_all_done_in  = 1'b1;
                  end
               end
            end
         end
         ST_FIFO: begin
            // Slot number is back; fetch its burst and remaining time.
            tbl_re   = 1'b1;
            slot_in  = fifo_rdata;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // Pop the head, update the clock and the remaining time.
            for (int l = 0; l < NUM_LEVELS; l++) begin
               if (LEVEL_W'(l) == lvl_ff) begin
                  head_in[l]  = (head_ff[l] == SLOT_W'(MAX_PROCS - 1)) ?
                                '0 : head_ff[l] + SLOT_W'(1);
                  count_in[l] = count_ff[l] - CNT_W'(1);
               end
            end
            clock_in  = new_clock;
            tbl_we    = 1'b1;
            tbl_waddr = slot_ff;
            tbl_wdata = {cur_burst, new_rem};

            // Requeue at the tail of the target level unless finished.
            if (new_rem != '0) begin
               fifo_we = 1'b1;
               fifo_wdata = slot_ff;
               case (tgt_lvl)
                  LVL0:    fifo_waddr = {LVL0, tail_pos[0]};
                  LVL1:    fifo_waddr = {LVL1, tail_pos[1]};
                  default: fifo_waddr = {LVL2, tail_pos[2]};
               endcase
               for (int l = 0; l < NUM_LEVELS; l++) begin
                  if (LEVEL_W'(l) == tgt_lvl) begin
                     count_in[l] = count_in[l] + CNT_W'(1);
                  end
               end
            end

            rsp_valid_in     = 1'b1;
            rsp_accepted_in  = 1'b1;
            rsp_id_in        = ID_W'(SUM_W'(slot_ff) + SUM_W'(1));
            rsp_level_in     = lvl_ff;
            rsp_completed_in = (new_rem == '0);
            rsp_finish_in    = new_clock;
            rsp_wait_in      = (new_rem == '0) ? (new_clock - TIME_W'(cur_burst)) : '0;
            rsp_all_done_in  = (count_in[0] == '0) && (count_in[1] == '0) &&
                               (count_in[2] == '0);
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      period0_in = period0_ff;
      period1_in = period1_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LEVEL0_PERIOD: period0_in = csr_wdata;
            CSR_LEVEL1_PERIOD: period1_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_ff     <= '0;
         loaded_ff    <= '0;
         running_ff   <= 1'b0;
         period0_ff   <= RST_LEVEL0_PERIOD;
         period1_ff   <= RST_LEVEL1_PERIOD;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         loaded_ff    <= loaded_in;
         running_ff   <= running_in;
         period0_ff   <= period0_in;
         period1_ff   <= period1_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lvl_ff           <= lvl_in;
      slot_ff          <= slot_in;
      rsp_accepted_ff  <= rsp_accepted_in;
      rsp_id_ff        <= rsp_id_in;
      rsp_level_ff     <= rsp_level_in;
      rsp_completed_ff <= rsp_completed_in;
      rsp_finish_ff    <= rsp_finish_in;
      rsp_wait_ff      <= rsp_wait_in;
      rsp_all_done_ff  <= rsp_all_done_in;
   end

   // Three circular queues, one region of the memory per level.
   mfqs_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_waddr),
      .wr_data (fifo_wdata),
      .rd_en   (fifo_re),
      .rd_addr (fifo_raddr),
      .rd_data (fifo_rdata)
   );

   // Process table: burst length and remaining time per slot.
   mfqs_ram #(
      .WIDTH (TBL_W),
      .DEPTH (MAX_PROCS)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_served_id    = rsp_id_ff;
   assign rsp_served_level = rsp_level_ff;
   assign rsp_completed    = rsp_completed_ff;
   assign rsp_finish_time  = rsp_finish_ff;
   assign rsp_delay_time   = rsp_wait_ff;
   assign rsp_all_done     = rsp_all_done_ff;

endmodule

/* rtl/mfqs_checker.sv */
`include "assert_macros.svh"

module mfqs_checker
   import mfqs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_action,
   input logic [IN_BURST_W-1:0] req_burst_length,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_accepted,
   input logic [ID_W-1:0]       rsp_served_id,
   input logic                  rsp_completed,
   input logic [TIME_W-1:0]     rsp_finish_time,
   input logic [TIME_W-1:0]     rsp_delay_time
);

   // A stalled response keeps its contents.
   `MFQS_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_served_id) && $stable(rsp_finish_time),
      "response changed while stalled")

   // A request that was not carried out names no process.
   `MFQS_ASSERT(a_reject_fields, clock, reset,
      rsp_valid && !rsp_accepted |->
         rsp_served_id == 0 && !rsp_completed && rsp_delay_time == 0,
      "rejected request shows a process")

   // A load with zero burst is answered in the next cycle as rejected.
   `MFQS_ASSERT(a_zero_load, clock, reset,
      req_valid && req_ready && req_action == ACT_LOAD && req_burst_length == 0 |=>
         rsp_valid && !rsp_accepted,
      "zero burst load not rejected")

   // No response is pending just after reset.
   `MFQS_ASSERT(a_reset_quiet, clock, reset, $past(reset) |-> !rsp_valid, "response pending after reset")

endmodule

bind multilevel_feedback_queue_scheduler mfqs_checker u_mfqs_checker (.*);

/* test/multilevel_feedback_queue_scheduler_tb.sv */
module multilevel_feedback_queue_scheduler_tb
   import mfqs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PROCS  = DEF_MAX_PROCS;
   localparam int SLOT_W = $clog2(DEF_MAX_PROCS);

   typedef struct packed {
      logic                  action;
      logic [IN_BURST_W-1:0] burst;
   } sched_request_type;

   typedef struct packed {
      logic               accepted;
      logic [ID_W-1:0]    id;
      logic [LEVEL_W-1:0] level;
      logic               completed;
      logic [TIME_W-1:0]  finish;
      logic [TIME_W-1:0]  waiting;
      logic               all_done;
   } sched_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_action = ACT_LOAD;
   logic [IN_BURST_W-1:0] req_burst_length = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_accepted;
   logic [ID_W-1:0]       rsp_served_id;
   logic [LEVEL_W-1:0]    rsp_served_level;
   logic                  rsp_completed;
   logic [TIME_W-1:0]     rsp_finish_time;
   logic [TIME_W-1:0]     rsp_delay_time;
   logic                  rsp_all_done;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_LEVEL0_PERIOD;
   logic [PERIOD_W-1:0]   csr_wdata = '0;

   multilevel_feedback_queue_scheduler DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_burst_length (req_burst_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_served_id    (rsp_served_id),
      .rsp_served_level (rsp_served_level),
      .rsp_completed    (rsp_completed),
      .rsp_finish_time  (rsp_finish_time),
      .rsp_delay_time   (rsp_delay_time),
      .rsp_all_done     (rsp_all_done),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Requests still to be offered, and outcomes awaited in order.
   sched_request_type request_queue[$];
   sched_result_type  awaited_outcomes[$];

   int errors       = 0;
   int ticks_queued = 0;
   int req_idle     = 0;
   int rsp_idle     = 0;
   int rsp_hold     = 0;
   int stall_asked  = 0;
   int stall_seen   = 0;
   bit calm         = 1'b0;

   // Scheduler state as the testbench expects it to be.
   logic [SLOT_W-1:0]     queue_slot [NUM_LEVELS][PROCS];
   int                    queue_head [NUM_LEVELS] = '{0, 0, 0};
   int                    queue_count [NUM_LEVELS] = '{0, 0, 0};
   logic [IN_BURST_W-1:0] proc_burst [PROCS];
   logic [IN_BURST_W-1:0] proc_left [PROCS];
   logic [TIME_W-1:0]     sched_time = '0;
   int                    procs_loaded = 0;
   bit                    ticking_started = 1'b0;
   logic [PERIOD_W-1:0]   demote_shift [2] = '{RST_LEVEL0_PERIOD, RST_LEVEL1_PERIOD};

   initial begin
      forever #10 clock = ~clock;
   end

   // Places a process at the tail of a level.
   function automatic void append_to_level(int lvl, logic [SLOT_W-1:0] slot);
      queue_slot[lvl][(queue_head[lvl] + queue_count[lvl]) % PROCS] = slot;
      queue_count[lvl]++;
   endfunction

   // Works out the outcome of one request and advances the expected state.
   function automatic sched_result_type schedule_request(sched_request_type rq);
      sched_result_type  r;
      int                lvl;
      int                mask;
      logic [SLOT_W-1:0] slot;
      r = '0;
      if (rq.action == ACT_LOAD) begin
         if (!ticking_started && procs_loaded < PROCS && rq.burst != 0) begin
            slot = SLOT_W'(procs_loaded);
            proc_burst[slot] = rq.burst;
            proc_left[slot] = rq.burst;
            append_to_level(LVL0, slot);
            procs_loaded++;
            r.accepted = 1'b1;
            r.id = ID_W'(slot) + ID_W'(1);
         end
      end else begin
         ticking_started = 1'b1;
         lvl = 0;
         while (lvl < NUM_LEVELS && queue_count[lvl] == 0)
            lvl++;
         if (lvl < NUM_LEVELS) begin
            slot = queue_slot[lvl][queue_head[lvl]];
            queue_head[lvl] = (queue_head[lvl] + 1) % PROCS;
            queue_count[lvl]--;
            r.accepted = 1'b1;
            r.id = ID_W'(slot) + ID_W'(1);
            r.level = LEVEL_W'(lvl);
            proc_left[slot] = proc_left[slot] - 1'b1;
            sched_time = sched_time + 1'b1;
            if (proc_left[slot] == 0) begin
               r.completed = 1'b1;
               r.waiting = sched_time - TIME_W'(proc_burst[slot]);
            end else if (lvl < 2) begin
               // Demotion follows the global clock, not the time spent in the level.
               mask = (1 << demote_shift[lvl]) - 1;
               if ((int'(sched_time) & mask) == 0)
                  append_to_level(lvl + 1, slot);
               else
                  append_to_level(lvl, slot);
            end else begin
               append_to_level(lvl, slot);
            end
         end
      end
      r.finish = sched_time;
      r.all_done = (queue_count[0] == 0 && queue_count[1] == 0 && queue_count[2] == 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   // Compares one response with the oldest awaited outcome.
   task automatic check_outcome(sched_result_type got);
      sched_result_type want;
      if (awaited_outcomes.size() == 0) begin
         report_mismatch("unexpected response", 1, 0);
      end else begin
         want = awaited_outcomes.pop_front();
         if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
         if (got.id !== want.id)
            report_mismatch("served_id", got.id, want.id);
         if (got.level !== want.level)
            report_mismatch("served_level", got.level, want.level);
         if (got.completed !== want.completed)
            report_mismatch("completed", got.completed, want.completed);
         if (got.finish !== want.finish)
            report_mismatch("finish_time", got.finish, want.finish);
         if (got.waiting !== want.waiting)
            report_mismatch("delay_time", got.waiting, want.waiting);
         if (got.all_done !== want.all_done)
            report_mismatch("all_done", got.all_done, want.all_done);
      end
   endtask

   // Request driver: predicts each accepted request, then offers the next one.
   always @(posedge clock) begin : drive_requests
      sched_request_type nxt;
      logic              offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            nxt.action = req_action;
            nxt.burst = req_burst_length;
            awaited_outcomes.push_back(schedule_request(nxt));
         end
         if (!(req_valid && !req_ready)) begin
            offer = 1'b0;
            if (req_idle > 0 && !calm) begin
               req_idle--;
            end else if (request_queue.size() != 0) begin
               nxt = request_queue.pop_front();
               req_action <= nxt.action;
               req_burst_length <= nxt.burst;
               offer = 1'b1;
               if (!calm && $urandom_range(0, 7) == 0)
                  req_idle = $urandom_range(1, 16);
            end
            req_valid <= offer;
         end
      end
   end

   // Response monitor: checks each accepted response and stalls at random.
   always @(posedge clock) begin : take_responses
      sched_result_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_accepted, rsp_served_id, rsp_served_level, rsp_completed,
                   rsp_finish_time, rsp_delay_time, rsp_all_done};
            check_outcome(got);
         end
         if (stall_seen != stall_asked) begin
            stall_seen = stall_asked;
            rsp_hold = 300;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (rsp_idle > 0 && !calm) begin
            rsp_idle--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
               rsp_idle = $urandom_range(1, 16);
         end
      end
   end

   task automatic push_request(logic action, logic [IN_BURST_W-1:0] burst);
      sched_request_type rq;
      rq.action = action;
      rq.burst = burst;
      request_queue.push_back(rq);
   endtask

   // Queues ticks, with refused loads scattered among them as noise.
   task automatic queue_ticks(int n, int noise_pct);
      int i;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            push_request(ACT_LOAD, IN_BURST_W'($urandom_range(0, 4095)));
         push_request(ACT_TICK, IN_BURST_W'($urandom_range(0, 4095)));
      end
      ticks_queued += n;
   endtask

   // Waits until every request is taken and every response has arrived.
   task automatic wait_idle();
      @(negedge clock);
      while (request_queue.size() != 0 || req_valid || awaited_outcomes.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_periods(logic [PERIOD_W-1:0] p0, logic [PERIOD_W-1:0] p1);
      csr_we <= 1'b1;
      csr_index <= CSR_LEVEL0_PERIOD;
      csr_wdata <= p0;
      @(posedge clock);
      csr_index <= CSR_LEVEL1_PERIOD;
      csr_wdata <= p1;
      @(posedge clock);
      csr_we <= 1'b0;
      demote_shift[0] = p0;
      demote_shift[1] = p1;
   endtask

   initial begin : run_schedule
      int                    work;
      int                    i;
      logic [IN_BURST_W-1:0] b;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // A zero burst is refused; then the table is filled with short bursts.
      push_request(ACT_LOAD, 12'd0);
      push_request(ACT_LOAD, 12'd1);
      push_request(ACT_LOAD, 12'd2);
      work = 3;
      for (i = 0; i < PROCS - 2; i++) begin
         b = IN_BURST_W'($urandom_range(70, 160));
         push_request(ACT_LOAD, b);
         work += b;
      end
      // The table is full now, so both loads are refused.
      push_request(ACT_LOAD, 12'hFFF);
      push_request(ACT_LOAD, 12'h555);
      // Once ticking has begun, every load is refused.
      push_request(ACT_TICK, 12'hAAA);
      ticks_queued = 1;
      push_request(ACT_LOAD, 12'd5);
      push_request(ACT_LOAD, 12'hFFF);

      // Default periods.
      queue_ticks(250, 5);
      wait_idle();

      // Shortest periods: every unfinished process from levels 0 and 1 drops.
      set_periods(4'd0, 4'd0);
      queue_ticks(200, 5);
      wait_idle();

      // Longest periods: nothing is demoted within the run.
      set_periods(4'd15, 4'd15);
      queue_ticks(200, 5);
      wait_idle();

      // The receiver holds off for a long stretch while requests keep coming.
      set_periods(4'd1, 4'd5);
      stall_asked++;
      queue_ticks(250, 5);
      wait_idle();

      // Last stretch without idling: run every process out, then tick on empty levels.
      set_periods(PERIOD_W'($urandom_range(0, 15)), PERIOD_W'($urandom_range(0, 15)));
      calm = 1'b1;
      queue_ticks(work - ticks_queued + 20, 3);
      wait_idle();

      if (errors == 0) begin
         $display("multilevel_feedback_queue_scheduler_tb passed");
      end else begin
         $display("multilevel_feedback_queue_scheduler_tb failed");
      end
      $finish;
   end

   initial begin : watchdog
      #10ms;
      $display("multilevel_feedback_queue_scheduler_tb failed");
      $finish;
   end

endmodule
